@@ rtl/core/rcc_pkg.sv @@
// Shared types and constants for the RGB/CMYK converter.
// No dependencies; every other file in rtl/core imports this package.
package rcc_pkg;

  localparam int CH_W      = 8;             // bits per color channel
  localparam int NUM_CH    = 3;             // channels handled by the divider lanes
  localparam int DIV_STEPS = CH_W;          // one quotient bit per divider cell
  localparam int PROD_W    = 2 * CH_W;      // width of channel x scale product

  localparam logic [CH_W-1:0] FULL_SCALE = 8'd255;

  // Direction codes carried in the action field
  localparam logic ACT_CMYK_TO_RGB = 1'b0;
  localparam logic ACT_RGB_TO_CMYK = 1'b1;

  // Per-beat control travelling with the divider lanes
  typedef struct packed {
    logic            action;   // direction of this beat
    logic [CH_W-1:0] k;        // black: input K (to RGB) or extracted K (to CMYK)
    logic            zero;     // force all three channel results to zero
    logic [CH_W-1:0] div;      // divisor shared by all three lanes
  } meta_t;

  // One divider lane: partial remainder and dividend/quotient shift word
  typedef struct packed {
    logic [CH_W-1:0] rem;
    logic [CH_W-1:0] low;
  } lane_t;

  typedef lane_t [NUM_CH-1:0] lanes_t;

endpackage

@@ rtl/core/rcc_prep.sv @@
// Front cell of the converter: black extraction, numerator product and divisor select.
// Depends on rcc_pkg.
module rcc_prep (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_action,
  input  logic [rcc_pkg::NUM_CH-1:0][7:0]  in_chan,
  input  logic [7:0]                       in_black,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rcc_pkg::meta_t                   out_meta,
  output rcc_pkg::lanes_t                  out_lanes
);
  import rcc_pkg::*;

  logic [NUM_CH-1:0][CH_W-1:0] inv;
  logic [NUM_CH-1:0][CH_W-1:0] num;
  logic [CH_W-1:0]             kmin;
  logic [CH_W-1:0]             mult;
  logic [PROD_W-1:0]           prod [NUM_CH];
  meta_t                       meta_next;
  logic                        vld;

  // Inverted channels and their minimum
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      inv[i] = FULL_SCALE - in_chan[i];
    end
    kmin = inv[0];
    if (inv[1] < kmin) begin
      kmin = inv[1];
    end
    if (inv[2] < kmin) begin
      kmin = inv[2];
    end
  end

  // CMYK->RGB: ink*(255-K)/255.  RGB->CMYK: (inv-K)*255/(255-K).
  always_comb begin
    meta_next.action = in_action;
    if (in_action == ACT_RGB_TO_CMYK) begin
      for (int i = 0; i < NUM_CH; i++) begin
        num[i] = inv[i] - kmin;
      end
      mult           = FULL_SCALE;
      meta_next.k    = kmin;
      meta_next.zero = (kmin == FULL_SCALE);
      meta_next.div  = FULL_SCALE - kmin;
    end else begin
      num            = in_chan;
      mult           = FULL_SCALE - in_black;
      meta_next.k    = in_black;
      meta_next.zero = 1'b0;
      meta_next.div  = FULL_SCALE;
    end
    for (int i = 0; i < NUM_CH; i++) begin
      prod[i] = PROD_W'(num[i]) * PROD_W'(mult);
    end
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_meta <= meta_next;
      for (int i = 0; i < NUM_CH; i++) begin
        out_lanes[i].rem <= prod[i][PROD_W-1:CH_W];
        out_lanes[i].low <= prod[i][CH_W-1:0];
      end
    end
  end

endmodule

@@ rtl/core/rcc_div_cell.sv @@
// One restoring-division cell: develops one quotient bit for each of the three lanes.
// Depends on rcc_pkg.
module rcc_div_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rcc_pkg::meta_t   in_meta,
  input  rcc_pkg::lanes_t  in_lanes,
  output logic             out_valid,
  input  logic             out_ready,
  output rcc_pkg::meta_t   out_meta,
  output rcc_pkg::lanes_t  out_lanes
);
  import rcc_pkg::*;

  lanes_t          lanes_next;
  logic [CH_W:0]   trial [NUM_CH];
  logic [NUM_CH-1:0] ge;
  logic            vld;

  // Shift in next dividend bit, subtract divisor if it fits
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      trial[i] = {in_lanes[i].rem, in_lanes[i].low[CH_W-1]};
      ge[i]    = (trial[i] >= {1'b0, in_meta.div});
      lanes_next[i].rem = ge[i] ? CH_W'(trial[i] - {1'b0, in_meta.div})
                                : trial[i][CH_W-1:0];
      lanes_next[i].low = {in_lanes[i].low[CH_W-2:0], ge[i]};
    end
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_meta  <= in_meta;
      out_lanes <= lanes_next;
    end
  end

endmodule

@@ rtl/core/rcc_out.sv @@
// Output cell: turns quotients into RGB or CMYK values and holds the result beat.
// Depends on rcc_pkg.
module rcc_out (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rcc_pkg::meta_t                   in_meta,
  input  rcc_pkg::lanes_t                  in_lanes,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rcc_pkg::NUM_CH-1:0][7:0]  out_chan,
  output logic [7:0]                       out_black
);
  import rcc_pkg::*;

  logic [NUM_CH-1:0][CH_W-1:0] chan_next;
  logic [CH_W-1:0]             black_next;
  logic                        vld;

  // Lanes now hold the quotients in their low words
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      if (in_meta.action == ACT_RGB_TO_CMYK) begin
        chan_next[i] = in_meta.zero ? '0 : in_lanes[i].low;
      end else begin
        // quotient + K never passes full scale for 8-bit inputs
        chan_next[i] = FULL_SCALE - in_lanes[i].low - in_meta.k;
      end
    end
    black_next = (in_meta.action == ACT_RGB_TO_CMYK) ? in_meta.k : '0;
  end

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_chan  <= chan_next;
      out_black <= black_next;
    end
  end

endmodule

@@ rtl/core/rgb_cmyk_converter.sv @@
// Converts one color per beat between 8-bit CMYK and 8-bit RGB; tuser picks the
// direction. Accepts one beat per clock unless the output stalls; made of a front cell
// (black extraction and 8x8 products), a chain of 8 division cells that each
// resolve one quotient bit for all three channels, and an output register. A cell
// holds its beat only while it is full and the next cell cannot take that beat, so
// bubbles close up.
// Depends on rcc_pkg, rcc_prep, rcc_div_cell and rcc_out.
module rgb_cmyk_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // cyan_or_red, magenta_or_green, yellow_or_blue, black_ink
  input  logic [0:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // out_cyan_or_red, out_magenta_or_green,
                                      // out_yellow_or_blue, out_black
);
  import rcc_pkg::*;

  logic [NUM_CH-1:0][CH_W-1:0] in_chan;
  logic [NUM_CH-1:0][CH_W-1:0] res_chan;
  logic [CH_W-1:0]             res_black;

  // Chain links: index 0 is the front cell output, DIV_STEPS the last divider output
  logic   [DIV_STEPS:0] link_valid;
  logic   [DIV_STEPS:0] link_ready;
  meta_t                link_meta  [DIV_STEPS+1];
  lanes_t               link_lanes [DIV_STEPS+1];

  assign in_chan[0] = s_axis_tdata[7:0];
  assign in_chan[1] = s_axis_tdata[15:8];
  assign in_chan[2] = s_axis_tdata[23:16];

  rcc_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser[0]),
    .in_chan   (in_chan),
    .in_black  (s_axis_tdata[31:24]),
    .out_valid (link_valid[0]),
    .out_ready (link_ready[0]),
    .out_meta  (link_meta[0]),
    .out_lanes (link_lanes[0])
  );

  // Division chain, one quotient bit per cell
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    rcc_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[g]),
      .in_ready  (link_ready[g]),
      .in_meta   (link_meta[g]),
      .in_lanes  (link_lanes[g]),
      .out_valid (link_valid[g+1]),
      .out_ready (link_ready[g+1]),
      .out_meta  (link_meta[g+1]),
      .out_lanes (link_lanes[g+1])
    );
  end

  rcc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (link_valid[DIV_STEPS]),
    .in_ready  (link_ready[DIV_STEPS]),
    .in_meta   (link_meta[DIV_STEPS]),
    .in_lanes  (link_lanes[DIV_STEPS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_chan  (res_chan),
    .out_black (res_black)
  );

  assign m_axis_tdata = {res_black, res_chan[2], res_chan[1], res_chan[0]};

endmodule

@@ sim/rgb_cmyk_converter_tb.sv @@
// Self-checking testbench for rgb_cmyk_converter: streams colors in both directions
// and compares every output beat with an in-bench integer model of the conversion.
// Depends on rcc_pkg and the converter RTL only.
module rgb_cmyk_converter_tb;
  import rcc_pkg::*;

  localparam int unsigned SCALE       = FULL_SCALE;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_WAIT  = 16;    // settle time after the last expected result

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // cyan_or_red, magenta_or_green, yellow_or_blue, black_ink
  logic [0:0]  s_axis_tuser = '0;  // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;       // out_cyan_or_red, out_magenta_or_green,
                                   // out_yellow_or_blue, out_black

  logic [31:0] expected_colors[$];
  int          errors = 0;
  int          colors_checked = 0;
  int          cmyk_beats = 0;
  int          rgb_beats = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          idle_on = 1'b1;

  rgb_cmyk_converter uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Color model
  // ---------------------------------------------------------------------------

  // One ink plus black, folded into a light level
  function automatic logic [7:0] ink_to_level(input logic [7:0] ink, input logic [7:0] k);
    int unsigned sum;
    sum = (int'(ink) * (SCALE - int'(k))) / SCALE + int'(k);
    if (sum > SCALE) sum = SCALE;
    return 8'(SCALE - sum);
  endfunction

  // Inverted channel with black removed, stretched back to full scale
  function automatic logic [7:0] spread_ink(input int unsigned inv, input int unsigned k);
    return 8'(((inv - k) * SCALE) / (SCALE - k));
  endfunction

  function automatic logic [31:0] predict_color(input logic act, input logic [31:0] d);
    logic [7:0]  res[3];
    logic [7:0]  k_out;
    int unsigned inv[3];
    int unsigned kk;
    k_out = '0;
    if (act == ACT_CMYK_TO_RGB) begin
      for (int i = 0; i < 3; i++)
        res[i] = (d[31:24] == FULL_SCALE) ? 8'd0 : ink_to_level(d[i*8 +: 8], d[31:24]);
    end else begin
      for (int i = 0; i < 3; i++) inv[i] = SCALE - int'(d[i*8 +: 8]);
      kk = inv[0];
      if (inv[1] < kk) kk = inv[1];
      if (inv[2] < kk) kk = inv[2];
      for (int i = 0; i < 3; i++) res[i] = (kk == SCALE) ? 8'd0 : spread_ink(inv[i], kk);
      k_out = kk[7:0];
    end
    return {k_out, res[2], res[1], res[0]};
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: check output beats first, then record accepted input beats
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : score_colors
    logic [31:0] want;
    string       field_name[4];
    field_name = '{"out_cyan_or_red", "out_magenta_or_green", "out_yellow_or_blue",
                   "out_black"};
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_colors.size() == 0) begin
          errors++;
          $display("%0t: unexpected output beat, actual %h", $time, m_axis_tdata);
        end else begin
          want = expected_colors.pop_front();
          colors_checked++;
          for (int f = 0; f < 4; f++)
            if (m_axis_tdata[f*8 +: 8] !== want[f*8 +: 8]) begin
              errors++;
              $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name[f],
                       want[f*8 +: 8], m_axis_tdata[f*8 +: 8]);
            end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_colors.push_back(predict_color(s_axis_tuser[0], s_axis_tdata));
        if (s_axis_tuser[0] == ACT_CMYK_TO_RGB) cmyk_beats++;
        else rgb_beats++;
      end
    end
  end

  // Output side: random stall after each accepted beat while idle_on is set
  always @(posedge clk) begin : drive_ready
    logic rdy_next;
    rdy_next = 1'b1;
    if (rst) begin
      rdy_next = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      rdy_next = 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      stall_left = idle_on ? $urandom_range(0, 3) : 0;
      if (stall_left > 0) begin
        stall_left--;
        rdy_next = 1'b0;
      end
    end
    m_axis_tready <= rdy_next;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still pending", $time, expected_colors.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus tasks (all entered and left on a rising edge)
  // ---------------------------------------------------------------------------
  task automatic send_color(input logic act, input logic [7:0] c0, input logic [7:0] c1,
                            input logic [7:0] c2, input logic [7:0] k);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {k, c2, c1, c0};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Hold the input off until every pending result has come back
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // CMYK to RGB: white, full inks, full black, black just below full, mixed values
    send_color(ACT_CMYK_TO_RGB, 8'd0,   8'd0,   8'd0,   8'd0);
    send_color(ACT_CMYK_TO_RGB, 8'd255, 8'd255, 8'd255, 8'd0);
    send_color(ACT_CMYK_TO_RGB, 8'd0,   8'd128, 8'd255, 8'd255);
    send_color(ACT_CMYK_TO_RGB, 8'd255, 8'd1,   8'd0,   8'd254);
    send_color(ACT_CMYK_TO_RGB, 8'd255, 8'd255, 8'd255, 8'd128);
    send_color(ACT_CMYK_TO_RGB, 8'hAA,  8'h55,  8'hAA,  8'h55);
    send_color(ACT_CMYK_TO_RGB, 8'h55,  8'hAA,  8'h55,  8'hAA);
    send_color(ACT_CMYK_TO_RGB, 8'd1,   8'd254, 8'd127, 8'd1);
    // RGB to CMYK: pure black, white, primaries, near black, grays, a mixed color
    send_color(ACT_RGB_TO_CMYK, 8'd0,   8'd0,   8'd0,   8'd0);
    send_color(ACT_RGB_TO_CMYK, 8'd255, 8'd255, 8'd255, 8'd0);
    send_color(ACT_RGB_TO_CMYK, 8'd255, 8'd0,   8'd0,   8'd0);
    send_color(ACT_RGB_TO_CMYK, 8'd0,   8'd255, 8'd0,   8'd0);
    send_color(ACT_RGB_TO_CMYK, 8'd0,   8'd0,   8'd255, 8'd0);
    send_color(ACT_RGB_TO_CMYK, 8'd1,   8'd1,   8'd1,   8'd0);
    send_color(ACT_RGB_TO_CMYK, 8'd1,   8'd0,   8'd0,   8'd0);
    send_color(ACT_RGB_TO_CMYK, 8'd254, 8'd254, 8'd254, 8'd0);
    send_color(ACT_RGB_TO_CMYK, 8'd128, 8'd64,  8'd32,  8'd0);
    // black field is ignored for this direction
    send_color(ACT_RGB_TO_CMYK, 8'hAA,  8'h55,  8'hAA,  8'd255);
    send_color(ACT_RGB_TO_CMYK, 8'h55,  8'hAA,  8'h55,  8'hAA);
    send_color(ACT_RGB_TO_CMYK, 8'd0,   8'd0,   8'd0,   8'd255);
    wait_for_results();
  endtask

  // Random mix of both directions, biased toward the black corner cases
  task automatic test_random_mix(input int count);
    logic       act;
    logic [7:0] c0, c1, c2, k;
    int         shape;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i % 400 == 399) wait_for_results();
      act   = 1'($urandom_range(0, 1));
      shape = $urandom_range(0, 7);
      c0 = 8'($urandom); c1 = 8'($urandom); c2 = 8'($urandom); k = 8'($urandom);
      if (act == ACT_CMYK_TO_RGB) begin
        case (shape)
          0: k = FULL_SCALE;
          1: k = 8'(FULL_SCALE - $urandom_range(0, 3));
          2: begin c0 = FULL_SCALE; c1 = FULL_SCALE; c2 = FULL_SCALE; end
          default: ;
        endcase
      end else begin
        case (shape)
          0: begin c1 = c0; c2 = c0; end
          1: begin c0 = 8'($urandom_range(0, 3)); c1 = 8'($urandom_range(0, 3));
                   c2 = 8'($urandom_range(0, 3)); end
          2: c1 = FULL_SCALE;
          default: ;
        endcase
      end
      send_color(act, c0, c1, c2, k);
    end
    idle_on = 1'b1;
    wait_for_results();
  endtask

  // Full-rate streaming with no gaps on either side
  task automatic test_back_to_back(input int count);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++)
      send_color(logic'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom));
    idle_on = 1'b1;
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_mix(1500);
    test_back_to_back(200);

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Converted %0d CMYK->RGB and %0d RGB->CMYK beats, %0d results checked,",
             cmyk_beats, rgb_beats, colors_checked);
    $display("with random and zero-gap handshakes on both sides; %0d mismatches.", errors);
    if (errors == 0 && expected_colors.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rcc_pkg.sv
rtl/core/rcc_prep.sv
rtl/core/rcc_div_cell.sv
rtl/core/rcc_out.sv
rtl/core/rgb_cmyk_converter.sv
sim/rgb_cmyk_converter_tb.sv
